@@ rtl/mml_pkg.sv @@
package mml_pkg;

  localparam int unsigned OperandBits = 31;
  localparam int unsigned CountBits = $clog2(OperandBits + 1);

  typedef logic [OperandBits-1:0] operand_t;
  typedef logic [CountBits-1:0] count_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StReduce,
    StScan,
    StMulA,
    StMulB,
    StDone
  } state_e;

  // Launch strobe from the sequencer to the multiplier.
  typedef struct packed {
    logic start;
  } mul_ctrl_t;

endpackage

@@ rtl/mml_if.sv @@
interface mml_in_if;
  logic               valid;
  logic               ready;
  mml_pkg::operand_t  base;
  mml_pkg::operand_t  exponent;
  mml_pkg::operand_t  modulus;

  modport source (output valid, base, exponent, modulus, input ready);
  modport sink (input valid, base, exponent, modulus, output ready);
endinterface

interface mml_out_if;
  logic               valid;
  logic               ready;
  mml_pkg::operand_t  power_result;

  modport source (output valid, power_result, input ready);
  modport sink (input valid, power_result, output ready);
endinterface

@@ rtl/modexp_montgomery_ladder.sv @@
// Flow: the base is reduced and the first product launched, leading zero bits of the
// exponent are skipped, then each ladder bit takes two modular products.
// Throughput: one item at a time; the input is ready the cycle after the result beat.
// Reset clears the sequencer to idle; data registers are not reset.
module modexp_montgomery_ladder (
  input  logic       clk_i,
  input  logic       rst_ni,
  mml_in_if.sink     in_if,
  mml_out_if.source  out_if
);

  mml_pkg::mul_ctrl_t ctrl;
  mml_pkg::operand_t  mul_a, mul_b, mul_m, mul_p;
  logic               mul_done;

  mml_seq u_seq (
    .clk_i, .rst_ni, .in_if, .out_if,
    .ctrl_o(ctrl), .mul_done_i(mul_done), .mul_p_i(mul_p),
    .mul_a_o(mul_a), .mul_b_o(mul_b), .mul_m_o(mul_m)
  );

  mml_mulmod u_mul (
    .clk_i, .rst_ni, .start_i(ctrl.start),
    .a_i(mul_a), .b_i(mul_b), .m_i(mul_m),
    .done_o(mul_done), .p_o(mul_p)
  );

endmodule

@@ rtl/mml_mulmod.sv @@
// Bit-serial modular multiplier: one bit of b per cycle, MSB first.
module mml_mulmod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  mml_pkg::operand_t a_i,
  input  mml_pkg::operand_t b_i,
  input  mml_pkg::operand_t m_i,
  output logic              done_o,
  output mml_pkg::operand_t p_o
);

  logic [mml_pkg::OperandBits:0] acc_q, acc_d, dbl, dbl_r, add, add_r;
  mml_pkg::operand_t a_q, b_q, m_q;
  mml_pkg::count_t   cnt_q;
  logic              busy_q, done_q;

  // One shift-reduce and add-reduce step.
  always_comb begin
    dbl   = {acc_q[mml_pkg::OperandBits-1:0], 1'b0};
    dbl_r = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    add   = dbl_r + {1'b0, a_q};
    add_r = (add >= {1'b0, m_q}) ? add - {1'b0, m_q} : add;
    acc_d = b_q[mml_pkg::OperandBits-1] ? add_r : dbl_r;
  end

  // Step counter and operand registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= mml_pkg::count_t'(mml_pkg::OperandBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == mml_pkg::count_t'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
      m_q   <= m_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[mml_pkg::OperandBits-2:0], 1'b0};
    end
  end

  // A zero modulus reduces everything to zero.
  assign p_o    = (m_q == '0) ? '0 : acc_q[mml_pkg::OperandBits-1:0];
  assign done_o = done_q;

endmodule

@@ rtl/mml_seq.sv @@
// Ladder sequencer: reduces the base, skips leading zeros, issues two products per bit.
module mml_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  mml_in_if.sink              in_if,
  mml_out_if.source           out_if,
  output mml_pkg::mul_ctrl_t  ctrl_o,
  input  logic                mul_done_i,
  input  mml_pkg::operand_t   mul_p_i,
  output mml_pkg::operand_t   mul_a_o,
  output mml_pkg::operand_t   mul_b_o,
  output mml_pkg::operand_t   mul_m_o
);

  mml_pkg::state_e   state_q, state_d;
  mml_pkg::operand_t lo_q, hi_q, exp_q, mod_q;
  mml_pkg::count_t   bit_q;
  logic              bit_v;

  assign bit_v = exp_q[mml_pkg::OperandBits-1];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mml_pkg::StIdle:   if (in_if.valid) state_d = mml_pkg::StReduce;
      mml_pkg::StReduce: if (mul_done_i) state_d = mml_pkg::StScan;
      mml_pkg::StScan: begin
        if (bit_q == '0) state_d = mml_pkg::StDone;
        else if (bit_v) state_d = mml_pkg::StMulA;
      end
      mml_pkg::StMulA:   if (mul_done_i) state_d = mml_pkg::StMulB;
      mml_pkg::StMulB: begin
        if (mul_done_i) state_d = (bit_q == '0) ? mml_pkg::StDone : mml_pkg::StMulA;
      end
      mml_pkg::StDone:   if (out_if.ready) state_d = mml_pkg::StIdle;
      default:           state_d = mml_pkg::StIdle;
    endcase
  end

  // Outputs and multiplier launch.
  always_comb begin
    in_if.ready  = (state_q == mml_pkg::StIdle);
    out_if.valid = (state_q == mml_pkg::StDone);
    ctrl_o.start = ((state_q == mml_pkg::StIdle) && in_if.valid) ||
                   ((state_q == mml_pkg::StScan) && bit_v && (bit_q != '0)) ||
                   ((state_q == mml_pkg::StMulA) && mul_done_i) ||
                   ((state_q == mml_pkg::StMulB) && mul_done_i && (bit_q != '0));
    mul_m_o = mod_q;
    unique case (state_q)
      mml_pkg::StIdle: begin
        // The base times one gives the base reduced by the modulus.
        mul_a_o = mml_pkg::operand_t'(1);
        mul_b_o = in_if.base;
        mul_m_o = in_if.modulus;
      end
      mml_pkg::StScan: begin
        mul_a_o = lo_q;
        mul_b_o = hi_q;
      end
      mml_pkg::StMulB: begin
        // The next cross product takes the square that lands at this edge.
        mul_a_o = bit_v ? lo_q : mul_p_i;
        mul_b_o = bit_v ? mul_p_i : hi_q;
      end
      default: begin
        // The second product squares the value that the bit picks.
        mul_a_o = bit_v ? hi_q : lo_q;
        mul_b_o = bit_v ? hi_q : lo_q;
      end
    endcase
  end

  assign out_if.power_result = lo_q;

  // Ladder registers. The exponent shifts left once per skipped or finished bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mml_pkg::StIdle;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == mml_pkg::StIdle && in_if.valid) begin
        bit_q <= mml_pkg::count_t'(mml_pkg::OperandBits);
      end else if ((state_q == mml_pkg::StScan && bit_q != '0 && !bit_v) ||
                   (state_q == mml_pkg::StMulA && mul_done_i)) begin
        bit_q <= bit_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      mml_pkg::StIdle: begin
        lo_q  <= mml_pkg::operand_t'(1);
        hi_q  <= in_if.base;
        exp_q <= in_if.exponent;
        mod_q <= in_if.modulus;
      end
      mml_pkg::StReduce: begin
        if (mul_done_i) hi_q <= mul_p_i;
      end
      mml_pkg::StScan: begin
        if (!bit_v) exp_q <= {exp_q[mml_pkg::OperandBits-2:0], 1'b0};
      end
      mml_pkg::StMulA: begin
        // Cross product lands in lo for a set bit, hi for a clear one.
        if (mul_done_i) begin
          if (bit_v) lo_q <= mul_p_i;
          else hi_q <= mul_p_i;
        end
      end
      mml_pkg::StMulB: begin
        if (mul_done_i) begin
          if (bit_v) hi_q <= mul_p_i;
          else lo_q <= mul_p_i;
          exp_q <= {exp_q[mml_pkg::OperandBits-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/mml_checker.sv @@
module mml_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input mml_pkg::operand_t out_power_result_i
);

  // A beat in leaves the block busy the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i) else $error("ready after accept");

  // Never ready while a result waits.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_i && in_ready_i)) else $error("ready with pending result");

  // Stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_power_result_i))
    else $error("result dropped");

  // Delivered result returns the block to ready.
  a_ret: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> in_ready_i) else $error("not ready after delivery");

endmodule

bind modexp_montgomery_ladder mml_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .out_power_result_i(out_if.power_result)
);
